// ===== rtl/box_shell_point_sampler_assert.svh =====
// Assertion macros for the box shell point sampler checker.
// Each macro expects clk and arst_n in scope.
`ifndef BOX_SHELL_POINT_SAMPLER_ASSERT_SVH
`define BOX_SHELL_POINT_SAMPLER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define BSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants of the box shell point sampler.
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam int LEN_W   = 30;   // Q14.16 lengths
	localparam int OUTER_W = 31;   // half length plus wall
	localparam int FRAC_W  = 25;   // Q0.24 fractions, 1.0 included
	localparam int DRAW_W  = 24;   // Q0.24 draws
	localparam int POS_W   = 33;   // signed Q16.16 coordinates
	localparam int REQ_W   = 3;
	localparam int IDX_W   = 3;

	localparam int S_DATA_W = 120;
	localparam int M_DATA_W = 104;

	// Region codes
	localparam logic [REQ_W-1:0] REGION_CENTER  = 3'd0;
	localparam logic [REQ_W-1:0] REGION_SHELL   = 3'd1;
	localparam logic [REQ_W-1:0] REGION_INSIDE  = 3'd2;
	localparam logic [REQ_W-1:0] REGION_INNER_S = 3'd3;
	localparam logic [REQ_W-1:0] REGION_OUTER_S = 3'd4;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_HALF_X  = 3'd0;
	localparam logic [IDX_W-1:0] REG_HALF_Y  = 3'd1;
	localparam logic [IDX_W-1:0] REG_HALF_Z  = 3'd2;
	localparam logic [IDX_W-1:0] REG_WALL    = 3'd3;
	localparam logic [IDX_W-1:0] REG_Z_VOL   = 3'd4;
	localparam logic [IDX_W-1:0] REG_Y_VOL   = 3'd5;
	localparam logic [IDX_W-1:0] REG_Z_SURF  = 3'd6;
	localparam logic [IDX_W-1:0] REG_Y_SURF  = 3'd7;

	typedef struct packed {
		logic [LEN_W-1:0]  half_x;
		logic [LEN_W-1:0]  half_y;
		logic [LEN_W-1:0]  half_z;
		logic [LEN_W-1:0]  wall;
		logic [FRAC_W-1:0] z_vol;
		logic [FRAC_W-1:0] y_vol;
		logic [FRAC_W-1:0] z_surf;
		logic [FRAC_W-1:0] y_surf;
	} cfg_t;

	// One axis: pos = offset + round(draw * mult / 2^(wall ? 24 : 23))
	typedef struct packed {
		logic [DRAW_W-1:0]       draw;
		logic [OUTER_W-1:0]      mult;
		logic                    wall;
		logic signed [POS_W-1:0] offset;
	} axis_op_t;

endpackage

// ===== rtl/box_shell_point_sampler.sv =====
// ----------------------------------------------------------------------------
// box_shell_point_sampler
// Samples one point in the box frame per word: center, in a box, its wall or on a face.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tuser: req_type; tdata: face, side, x, y, z draws
//  m_*      | out       | tuser: bad_region; tdata: point x, y, z
//  cfg_*    | in        | register index and value, written on cfg_we
//
//  One word per cycle while m_tready is high; a taken word is registered in
//  stage 1, then stage 2. Stage 1 holds the decoded per-axis operands, stage
//  2 the point after three parallel 24 x 31 multiplies. A stall on m_tready
//  holds both stages; s_tready drops only while both are full and m_tready
//  is low. Reset clears the stage valids and the configuration registers.
// ----------------------------------------------------------------------------
module box_shell_point_sampler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// face_draw[23:0], side_draw[47:24], draw_x[71:48], draw_y[95:72], draw_z[119:96]
	input  logic [bss_pkg::S_DATA_W-1:0]    s_tdata,
	// req_type[2:0]
	input  logic [bss_pkg::REQ_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// point_x[32:0], point_y[65:33], point_z[98:66], zero fill above
	output logic [bss_pkg::M_DATA_W-1:0]    m_tdata,
	// bad_region[0]
	output logic                            m_tuser,
	input  logic                            cfg_we,
	input  logic [bss_pkg::IDX_W-1:0]       cfg_index,
	input  logic [bss_pkg::LEN_W-1:0]       cfg_data
);

	localparam int DW = bss_pkg::DRAW_W;
	localparam int PW = bss_pkg::POS_W;

	bss_pkg::cfg_t     cfg_q;
	bss_pkg::axis_op_t dec_x, dec_y, dec_z;
	logic              dec_bad;

	bss_pkg::axis_op_t op_x_s1, op_y_s1, op_z_s1;
	logic              bad_s1, valid_s1;

	logic signed [PW-1:0] pos_x, pos_y, pos_z;
	logic signed [PW-1:0] point_x_s2, point_y_s2, point_z_s2;
	logic                 bad_s2, valid_s2;

	logic ready_s2, ready_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bss_pkg::REG_HALF_X: cfg_q.half_x <= cfg_data;
				bss_pkg::REG_HALF_Y: cfg_q.half_y <= cfg_data;
				bss_pkg::REG_HALF_Z: cfg_q.half_z <= cfg_data;
				bss_pkg::REG_WALL:   cfg_q.wall   <= cfg_data;
				bss_pkg::REG_Z_VOL:  cfg_q.z_vol  <= cfg_data[bss_pkg::FRAC_W-1:0];
				bss_pkg::REG_Y_VOL:  cfg_q.y_vol  <= cfg_data[bss_pkg::FRAC_W-1:0];
				bss_pkg::REG_Z_SURF: cfg_q.z_surf <= cfg_data[bss_pkg::FRAC_W-1:0];
				bss_pkg::REG_Y_SURF: cfg_q.y_surf <= cfg_data[bss_pkg::FRAC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bss_decode u_decode (
		.req_type   (s_tuser),
		.face_draw  (s_tdata[DW-1:0]),
		.side_draw  (s_tdata[2*DW-1:DW]),
		.draw_x     (s_tdata[3*DW-1:2*DW]),
		.draw_y     (s_tdata[4*DW-1:3*DW]),
		.draw_z     (s_tdata[5*DW-1:4*DW]),
		.cfg        (cfg_q),
		.op_x       (dec_x),
		.op_y       (dec_y),
		.op_z       (dec_z),
		.bad_region (dec_bad)
	);

	assign ready_s2 = !valid_s2 || m_tready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	// Stage 1: decoded operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			op_x_s1 <= dec_x;
			op_y_s1 <= dec_y;
			op_z_s1 <= dec_z;
			bad_s1  <= dec_bad;
		end
	end

	bss_axis u_axis_x (.op(op_x_s1), .pos(pos_x));
	bss_axis u_axis_y (.op(op_y_s1), .pos(pos_y));
	bss_axis u_axis_z (.op(op_z_s1), .pos(pos_z));

	// Stage 2: result word, held while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			point_x_s2 <= pos_x;
			point_y_s2 <= pos_y;
			point_z_s2 <= pos_z;
			bad_s2     <= bad_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = bad_s2;
	assign m_tdata  = {{(bss_pkg::M_DATA_W - 3*PW){1'b0}}, point_z_s2, point_y_s2, point_x_s2};

endmodule

// ===== rtl/bss_decode.sv =====
// ----------------------------------------------------------------------------
// bss_decode
// Picks the face pair and side, and sets up the multiply and offset per axis.
// ----------------------------------------------------------------------------
module bss_decode (
	input  logic [bss_pkg::REQ_W-1:0]  req_type,
	input  logic [bss_pkg::DRAW_W-1:0] face_draw,
	input  logic [bss_pkg::DRAW_W-1:0] side_draw,
	input  logic [bss_pkg::DRAW_W-1:0] draw_x,
	input  logic [bss_pkg::DRAW_W-1:0] draw_y,
	input  logic [bss_pkg::DRAW_W-1:0] draw_z,
	input  bss_pkg::cfg_t              cfg,
	output bss_pkg::axis_op_t          op_x,
	output bss_pkg::axis_op_t          op_y,
	output bss_pkg::axis_op_t          op_z,
	output logic                       bad_region
);

	typedef enum logic [1:0] {FACE_Z, FACE_Y, FACE_X} face_t;

	function automatic bss_pkg::axis_op_t span_op(
		input logic [bss_pkg::DRAW_W-1:0]  d,
		input logic [bss_pkg::OUTER_W-1:0] h
	);
		bss_pkg::axis_op_t o;
		o.draw   = d;
		o.mult   = h;
		o.wall   = 1'b0;
		o.offset = -$signed({2'b00, h});
		return o;
	endfunction

	function automatic bss_pkg::axis_op_t wall_op(
		input logic [bss_pkg::DRAW_W-1:0] d,
		input logic [bss_pkg::LEN_W-1:0]  h,
		input logic [bss_pkg::LEN_W-1:0]  t,
		input logic                       minus
	);
		bss_pkg::axis_op_t o;
		o.draw   = d;
		o.mult   = {1'b0, t};
		o.wall   = 1'b1;
		o.offset = minus ? -($signed({3'b000, h}) + $signed({3'b000, t}))
		                 : $signed({3'b000, h});
		return o;
	endfunction

	function automatic bss_pkg::axis_op_t fixed_op(
		input logic [bss_pkg::OUTER_W-1:0] h,
		input logic                        minus
	);
		bss_pkg::axis_op_t o;
		o.draw   = '0;
		o.mult   = '0;
		o.wall   = 1'b0;
		o.offset = minus ? -$signed({2'b00, h}) : $signed({2'b00, h});
		return o;
	endfunction

	function automatic face_t pick_face(
		input logic [bss_pkg::DRAW_W-1:0] d,
		input logic [bss_pkg::FRAC_W-1:0] zf,
		input logic [bss_pkg::FRAC_W-1:0] yf
	);
		logic [bss_pkg::FRAC_W:0] lim;
		lim = {1'b0, zf} + {1'b0, yf};
		if ({1'b0, d} < zf)
			return FACE_Z;
		else if ({2'b00, d} < lim)
			return FACE_Y;
		else
			return FACE_X;
	endfunction

	logic [bss_pkg::OUTER_W-1:0] in_x, in_y, in_z;
	logic [bss_pkg::OUTER_W-1:0] out_x, out_y, out_z;
	logic                        minus;
	face_t                       vol_face, surf_face;
	bss_pkg::axis_op_t           zero;

	assign in_x  = {1'b0, cfg.half_x};
	assign in_y  = {1'b0, cfg.half_y};
	assign in_z  = {1'b0, cfg.half_z};
	assign out_x = in_x + {1'b0, cfg.wall};
	assign out_y = in_y + {1'b0, cfg.wall};
	assign out_z = in_z + {1'b0, cfg.wall};
	assign minus = ~side_draw[bss_pkg::DRAW_W-1];
	assign zero  = '0;

	assign vol_face  = pick_face(face_draw, cfg.z_vol, cfg.y_vol);
	assign surf_face = pick_face(face_draw, cfg.z_surf, cfg.y_surf);

	always_comb begin
		op_x       = zero;
		op_y       = zero;
		op_z       = zero;
		bad_region = 1'b0;
		case (req_type)
			bss_pkg::REGION_CENTER: begin
			end
			bss_pkg::REGION_SHELL: begin
				case (vol_face)
					FACE_Z: begin
						op_x = span_op(draw_x, out_x);
						op_y = span_op(draw_y, out_y);
						op_z = wall_op(draw_z, cfg.half_z, cfg.wall, minus);
					end
					FACE_Y: begin
						op_x = span_op(draw_x, out_x);
						op_y = wall_op(draw_y, cfg.half_y, cfg.wall, minus);
						op_z = span_op(draw_z, in_z);
					end
					default: begin
						op_x = wall_op(draw_x, cfg.half_x, cfg.wall, minus);
						op_y = span_op(draw_y, in_y);
						op_z = span_op(draw_z, in_z);
					end
				endcase
			end
			bss_pkg::REGION_INSIDE: begin
				op_x = span_op(draw_x, in_x);
				op_y = span_op(draw_y, in_y);
				op_z = span_op(draw_z, in_z);
			end
			bss_pkg::REGION_INNER_S: begin
				case (surf_face)
					FACE_Z: begin
						op_x = span_op(draw_x, in_x);
						op_y = span_op(draw_y, in_y);
						op_z = fixed_op(in_z, minus);
					end
					FACE_Y: begin
						op_x = span_op(draw_x, in_x);
						op_y = fixed_op(in_y, minus);
						op_z = span_op(draw_z, in_z);
					end
					default: begin
						op_x = fixed_op(in_x, minus);
						op_y = span_op(draw_y, in_y);
						op_z = span_op(draw_z, in_z);
					end
				endcase
			end
			bss_pkg::REGION_OUTER_S: begin
				case (surf_face)
					FACE_Z: begin
						op_x = span_op(draw_x, out_x);
						op_y = span_op(draw_y, out_y);
						op_z = fixed_op(out_z, minus);
					end
					FACE_Y: begin
						op_x = span_op(draw_x, out_x);
						op_y = fixed_op(out_y, minus);
						op_z = span_op(draw_z, out_z);
					end
					default: begin
						op_x = fixed_op(out_x, minus);
						op_y = span_op(draw_y, out_y);
						op_z = span_op(draw_z, out_z);
					end
				endcase
			end
			default: begin
				bad_region = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/bss_axis.sv =====
// ----------------------------------------------------------------------------
// bss_axis
// One coordinate: scaled draw, rounded to nearest (ties up), plus offset.
// ----------------------------------------------------------------------------
module bss_axis (
	input  bss_pkg::axis_op_t              op,
	output logic signed [bss_pkg::POS_W-1:0] pos
);

	localparam int PROD_W = bss_pkg::DRAW_W + bss_pkg::OUTER_W;

	logic [PROD_W-1:0]         prod;
	logic [PROD_W:0]           sum;
	logic [bss_pkg::POS_W-1:0] off;
	logic [bss_pkg::POS_W:0]   total;

	assign prod = {{bss_pkg::OUTER_W{1'b0}}, op.draw} * {{bss_pkg::DRAW_W{1'b0}}, op.mult};

	// Wall slabs scale by 2^-24, spans by 2^-23; add half an LSB first
	assign sum = {1'b0, prod} + (op.wall ? (PROD_W+1)'(1) << 23 : (PROD_W+1)'(1) << 22);
	assign off = op.wall ? {1'b0, sum[PROD_W:24]} : sum[PROD_W:23];

	assign total = {1'b0, off} + {op.offset[bss_pkg::POS_W-1], op.offset};
	assign pos   = $signed(total[bss_pkg::POS_W-1:0]);

endmodule

// ===== rtl/bss_checker.sv =====
// ----------------------------------------------------------------------------
// bss_checker
// Port-level checks of the box shell point sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_shell_point_sampler_assert.svh"

module bss_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [bss_pkg::M_DATA_W-1:0] m_tdata,
	input logic                         m_tuser
);

	logic out_stall;
	logic bad_word;

	assign out_stall = m_tvalid && !m_tready;
	assign bad_word  = m_tvalid && m_tuser;

	`BSS_ASSERT_NEXT(a_hold_word, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
	`BSS_ASSERT_NOW(a_bad_zero, bad_word, m_tdata == '0, "unknown region gave a nonzero point")
	`BSS_ASSERT_NOW(a_ready_only_full, !s_tready, out_stall, "input blocked while the output side moves")

endmodule

bind box_shell_point_sampler bss_checker u_bss_checker (.*);
